FILE: hdl/tbdp_pkg.sv
// Shared types and constants for the ternary bitplane dot product block.
`default_nettype none
package tbdp_pkg;

   // Lane layout of one input group
   localparam int LANES   = 8;
   localparam int ACT_W   = 16;
   // Eight lanes of 16-bit magnitude need four extra bits of headroom
   localparam int GROUP_W = ACT_W + 4;

   // Row accumulator and scale
   localparam int SUM_W   = 28;
   localparam int SCALE_W = 24;
   localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
   localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

   // Queue geometry (depth is a power of two)
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = QPTR_W + 1;

   // One classified group passed from front to back
   typedef struct packed {
      logic signed [GROUP_W-1:0] group_sum;
      logic [SCALE_W-1:0]        row_scale;
      logic                      last;
   } mid_item_type;

   // Handshake between queue and its neighbors
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage
`default_nettype wire

FILE: hdl/tbdp_front.sv
// Front end: applies ternary weights to the eight lanes and reduces them to a group sum.
`default_nettype none
module tbdp_front (
   input  wire logic [7:0]                                        plus_bits,
   input  wire logic [7:0]                                        minus_bits,
   input  wire logic [tbdp_pkg::LANES-1:0][tbdp_pkg::ACT_W-1:0]  act,
   input  wire logic [tbdp_pkg::SCALE_W-1:0]                      row_scale,
   input  wire logic                                              last,
   output tbdp_pkg::mid_item_type                                 item
);

   // Sum each lane as +a, -a or zero
   always_comb begin
      logic signed [tbdp_pkg::GROUP_W-1:0] sum;
      logic signed [tbdp_pkg::GROUP_W-1:0] lane_val;
      sum = '0;
      for (int lane = 0; lane < tbdp_pkg::LANES; lane++) begin
         lane_val = tbdp_pkg::GROUP_W'($signed(act[lane]));
         if (plus_bits[lane] && !minus_bits[lane]) begin
            sum = sum + lane_val;
         end else if (minus_bits[lane] && !plus_bits[lane]) begin
            sum = sum - lane_val;
         end
      end
      item.group_sum = sum;
      item.row_scale = row_scale;
      item.last      = last;
   end

endmodule
`default_nettype wire

FILE: hdl/tbdp_queue.sv
// Short queue of classified groups between front and back.
`default_nettype none
module tbdp_queue (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    push,
   input  tbdp_pkg::mid_item_type       push_item,
   input  wire logic                    pop,
   output tbdp_pkg::mid_item_type       head_item,
   output tbdp_pkg::queue_status_type   status
);

   tbdp_pkg::mid_item_type            mem_ff [tbdp_pkg::QUEUE_DEPTH];
   logic [tbdp_pkg::QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [tbdp_pkg::QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [tbdp_pkg::QCNT_W-1:0]       count_ff, count_in;
   logic                              do_push, do_pop;

   assign status.full  = (count_ff == tbdp_pkg::QCNT_W'(tbdp_pkg::QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign head_item    = mem_ff[rd_ptr_ff];

   // Advance pointers and count on each transfer
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the incoming item
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule
`default_nettype wire

FILE: hdl/tbdp_back.sv
// Back end: saturating row accumulation, row scaling and the result buffer.
`default_nettype none
module tbdp_back (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  tbdp_pkg::mid_item_type              head_item,
   input  tbdp_pkg::queue_status_type          mid_status,
   output logic                                mid_pop,
   input  wire logic                           rsp_pop,
   output logic                                rsp_empty,
   output logic signed [tbdp_pkg::SUM_W-1:0]   rsp_dot_result,
   output logic                                rsp_saturated
);

   typedef struct packed {
      logic signed [tbdp_pkg::SUM_W-1:0] dot_result;
      logic                              saturated;
   } result_type;

   // Accumulator state
   logic signed [tbdp_pkg::SUM_W-1:0]   acc_ff, acc_in;
   logic                                clip_ff, clip_in;
   logic [tbdp_pkg::SUM_W:0]            wide_sum;
   logic signed [tbdp_pkg::SUM_W-1:0]   sat_sum;
   logic                                sat_hit;

   // Scale stage
   logic                                m_valid_ff, m_valid_in;
   logic signed [tbdp_pkg::SUM_W-1:0]   m_sum_ff;
   logic [tbdp_pkg::SCALE_W-1:0]        m_scale_ff;
   logic                                m_clip_ff;
   logic signed [tbdp_pkg::SUM_W+tbdp_pkg::SCALE_W:0] product;

   // Result buffer
   result_type                          res_mem_ff [tbdp_pkg::QUEUE_DEPTH];
   logic [tbdp_pkg::QPTR_W-1:0]         res_wr_ff, res_rd_ff;
   logic [tbdp_pkg::QCNT_W-1:0]         res_count_ff, res_count_in;
   logic [tbdp_pkg::QCNT_W:0]           committed;
   logic                                res_push, res_pop;
   result_type                          res_head;

   // Take a group only when the result buffer has room for anything in flight
   assign committed = {1'b0, res_count_ff} + (tbdp_pkg::QCNT_W+1)'(m_valid_ff);
   assign mid_pop   = !mid_status.empty &&
                      (committed < (tbdp_pkg::QCNT_W+1)'(tbdp_pkg::QUEUE_DEPTH));

   // Add the group into the row sum and clip to the accumulator range
   always_comb begin
      wide_sum = {acc_ff[tbdp_pkg::SUM_W-1], acc_ff} +
                 {{(tbdp_pkg::SUM_W+1-tbdp_pkg::GROUP_W){head_item.group_sum[tbdp_pkg::GROUP_W-1]}},
                  head_item.group_sum};
      sat_hit = (wide_sum[tbdp_pkg::SUM_W] != wide_sum[tbdp_pkg::SUM_W-1]);
      if (!sat_hit) begin
         sat_sum = wide_sum[tbdp_pkg::SUM_W-1:0];
      end else if (wide_sum[tbdp_pkg::SUM_W]) begin
         sat_sum = tbdp_pkg::SUM_MIN;
      end else begin
         sat_sum = tbdp_pkg::SUM_MAX;
      end
   end

   // Accumulate each taken group into the row state; clear it after the last group
   always_comb begin
      acc_in     = acc_ff;
      clip_in    = clip_ff;
      m_valid_in = 1'b0;
      if (mid_pop) begin
         if (head_item.last) begin
            acc_in     = '0;
            clip_in    = 1'b0;
            m_valid_in = 1'b1;
         end else begin
            acc_in  = sat_sum;
            clip_in = clip_ff || sat_hit;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff     <= '0;
         clip_ff    <= 1'b0;
         m_valid_ff <= 1'b0;
      end else begin
         acc_ff     <= acc_in;
         clip_ff    <= clip_in;
         m_valid_ff <= m_valid_in;
      end
   end

   // Hold the finished row sum and scale for the multiplier
   always_ff @(posedge clock) begin
      if (mid_pop && head_item.last) begin
         m_sum_ff   <= sat_sum;
         m_scale_ff <= head_item.row_scale;
         m_clip_ff  <= clip_ff || sat_hit;
      end
   end

   // Scale the row sum; the arithmetic shift by the scale width floors the result
   assign product = m_sum_ff * $signed({1'b0, m_scale_ff});

   assign res_push = m_valid_ff;
   assign res_pop  = rsp_pop && !rsp_empty;

   always_comb begin
      res_count_in = res_count_ff;
      if (res_push && !res_pop) begin
         res_count_in = res_count_ff + 1'b1;
      end else if (res_pop && !res_push) begin
         res_count_in = res_count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         res_wr_ff    <= '0;
         res_rd_ff    <= '0;
         res_count_ff <= '0;
      end else begin
         if (res_push) begin
            res_wr_ff <= res_wr_ff + 1'b1;
         end
         if (res_pop) begin
            res_rd_ff <= res_rd_ff + 1'b1;
         end
         res_count_ff <= res_count_in;
      end
   end

   // Register the scaled result into the buffer
   always_ff @(posedge clock) begin
      if (res_push) begin
         res_mem_ff[res_wr_ff].dot_result <= product[tbdp_pkg::SCALE_W +: tbdp_pkg::SUM_W];
         res_mem_ff[res_wr_ff].saturated  <= m_clip_ff;
      end
   end

   assign res_head       = res_mem_ff[res_rd_ff];
   assign rsp_empty      = (res_count_ff == '0);
   assign rsp_dot_result = res_head.dot_result;
   assign rsp_saturated  = res_head.saturated;

endmodule
`default_nettype wire

FILE: hdl/ternary_bitplane_dot_product.sv
// Top level of the ternary bitplane dot product block.
//
// Input channel (req_): one group of eight lanes per transfer, taken when
// req_push is high and req_full is low. Each lane's weight is its plus bit
// minus its minus bit; req_last closes the row and req_row_scale applies to it.
// Result channel (rsp_): one result per row, shown while rsp_empty is low and
// transferred when rsp_pop is high. rsp_dot_result is the saturated row sum
// times the Q0.24 scale, floored back to Q13.15; rsp_saturated flags clipping.
// Throughput: one group per cycle while the result buffer has room, set by the
// combinational lane add tree in the front and the accumulator in the back.
// Path: a last group passes the group queue, the scale register and the result
// buffer, each registered, before its result shows on the result channel.
// Reset clears both queues, the row sum and the clip flag.
// When the receiver stalls, up to four results wait in the result buffer,
// then the four-entry group queue fills and req_full rises.
`default_nettype none
module ternary_bitplane_dot_product (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_push,
   output logic                                     req_full,
   input  wire logic [7:0]                          req_plus_bits,
   input  wire logic [7:0]                          req_minus_bits,
   input  wire logic signed [tbdp_pkg::ACT_W-1:0]   req_act_0,
   input  wire logic signed [tbdp_pkg::ACT_W-1:0]   req_act_1,
   input  wire logic signed [tbdp_pkg::ACT_W-1:0]   req_act_2,
   input  wire logic signed [tbdp_pkg::ACT_W-1:0]   req_act_3,
   input  wire logic signed [tbdp_pkg::ACT_W-1:0]   req_act_4,
   input  wire logic signed [tbdp_pkg::ACT_W-1:0]   req_act_5,
   input  wire logic signed [tbdp_pkg::ACT_W-1:0]   req_act_6,
   input  wire logic signed [tbdp_pkg::ACT_W-1:0]   req_act_7,
   input  wire logic [tbdp_pkg::SCALE_W-1:0]        req_row_scale,
   input  wire logic                                req_last,
   output logic                                     rsp_empty,
   input  wire logic                                rsp_pop,
   output logic signed [tbdp_pkg::SUM_W-1:0]        rsp_dot_result,
   output logic                                     rsp_saturated
);

   logic [tbdp_pkg::LANES-1:0][tbdp_pkg::ACT_W-1:0] act;
   tbdp_pkg::mid_item_type                          front_item;
   tbdp_pkg::mid_item_type                          head_item;
   tbdp_pkg::queue_status_type                      mid_status;
   logic                                            mid_pop;

   assign act = {req_act_7, req_act_6, req_act_5, req_act_4,
                 req_act_3, req_act_2, req_act_1, req_act_0};

   // Classify and reduce each incoming group
   tbdp_front u_front (
      .plus_bits  (req_plus_bits),
      .minus_bits (req_minus_bits),
      .act        (act),
      .row_scale  (req_row_scale),
      .last       (req_last),
      .item       (front_item)
   );

   // Decouple front from back
   tbdp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .push_item (front_item),
      .pop       (mid_pop),
      .head_item (head_item),
      .status    (mid_status)
   );

   assign req_full = mid_status.full;

   // Accumulate, scale and buffer results
   tbdp_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head_item      (head_item),
      .mid_status     (mid_status),
      .mid_pop        (mid_pop),
      .rsp_pop        (rsp_pop),
      .rsp_empty      (rsp_empty),
      .rsp_dot_result (rsp_dot_result),
      .rsp_saturated  (rsp_saturated)
   );

endmodule
`default_nettype wire

FILE: hdl/tbdp_checker.sv
// Port-level checks for the ternary bitplane dot product block, bound to the top level.
`default_nettype none
module tbdp_checker (
   input wire logic                               clock,
   input wire logic                               reset,
   input wire logic                               req_push,
   input wire logic                               req_full,
   input wire logic                               rsp_empty,
   input wire logic                               rsp_pop,
   input wire logic [tbdp_pkg::SUM_W-1:0]         rsp_dot_result,
   input wire logic                               rsp_saturated
);

   // Reset leaves both channels drained
   assert property (@(posedge clock) reset |=> rsp_empty && !req_full)
      else $error("channels not drained after reset");

   // A waiting result holds until it is transferred
   assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=>
         !rsp_empty && $stable(rsp_dot_result) && $stable(rsp_saturated))
      else $error("waiting result changed before transfer");

   // The input queue can only fill on a push
   assert property (@(posedge clock) disable iff (reset)
      $rose(req_full) |-> $past(req_push))
      else $error("full rose without a push");

   // A result cannot appear in the cycle right after reset
   assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> rsp_empty)
      else $error("result appeared straight out of reset");

endmodule

bind ternary_bitplane_dot_product tbdp_checker u_tbdp_checker (
   .clock          (clock),
   .reset          (reset),
   .req_push       (req_push),
   .req_full       (req_full),
   .rsp_empty      (rsp_empty),
   .rsp_pop        (rsp_pop),
   .rsp_dot_result (rsp_dot_result),
   .rsp_saturated  (rsp_saturated)
);
`default_nettype wire
